/* hdl/gcs_pkg.sv */
// Package for the gaze cursor select tracker.
// Holds the mode codes, register indexes and the structs passed between modules.
// No dependencies.
package gcs_pkg;

  // Output mode codes
  localparam logic [1:0] MODE_INIT    = 2'd0;
  localparam logic [1:0] MODE_CENTRAL = 2'd1;
  localparam logic [1:0] MODE_CLOSED  = 2'd2;
  localparam logic [1:0] MODE_MOVE    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_GOOD_INTENSITY   = 3'd0;
  localparam logic [2:0] REG_CLOSED_INTENSITY = 3'd1;
  localparam logic [2:0] REG_OPEN_INTENSITY   = 3'd2;
  localparam logic [2:0] REG_CLOSED_FRAMES    = 3'd3;
  localparam logic [2:0] REG_MOVE_OFFSET      = 3'd4;
  localparam logic [2:0] REG_JUMP_LIMIT       = 3'd5;

  // Smallest intensity that a good_intensity write may set is one above this
  localparam logic [15:0] GOOD_INTENSITY_FLOOR = 16'd100;

  // Tracker state, one-hot
  typedef enum logic [3:0] {
    ST_INIT    = 4'b0001,
    ST_CENTRAL = 4'b0010,
    ST_CLOSED  = 4'b0100,
    ST_MOVE    = 4'b1000
  } track_state_t;

  // Completed row/column/intensity triple from the byte assembler
  typedef struct packed {
    logic        valid;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] intensity;
  } gcs_triple_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] good_intensity;
    logic [15:0] closed_intensity;
    logic [15:0] open_intensity;
    logic [7:0]  closed_frames_needed;
    logic [15:0] move_offset;
    logic [15:0] jump_limit;
  } gcs_cfg_t;

  // One tracker result
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  key_index;
    logic        select_pulse;
    logic [15:0] row_shown;
    logic [15:0] col_shown;
    logic [15:0] intensity_shown;
  } gcs_result_t;

endpackage

/* hdl/gcs_assemble.sv */
// Byte assembler: pairs bytes into big-endian 16-bit numbers and groups
// them into row, column, intensity triples. Depends on gcs_pkg.
module gcs_assemble
  import gcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  byte_in,
  output gcs_triple_t triple
);

  logic        low_byte_next;
  logic [7:0]  high_byte;
  logic [1:0]  field_count;
  logic [15:0] raw_row;
  logic [15:0] raw_col;
  logic [15:0] number;

  assign number = {high_byte, byte_in};

  // A triple completes on the low byte of the third number
  always_comb begin
    triple.valid     = low_byte_next && (field_count == 2'd2);
    triple.row       = raw_row;
    triple.col       = raw_col;
    triple.intensity = number;
  end

  // Byte pairing and field counting
  always_ff @(posedge clk) begin
    if (rst) begin
      low_byte_next <= 1'b0;
      high_byte     <= '0;
      field_count   <= '0;
      raw_row       <= '0;
      raw_col       <= '0;
    end else if (advance) begin
      if (!low_byte_next) begin
        high_byte     <= byte_in;
        low_byte_next <= 1'b1;
      end else begin
        low_byte_next <= 1'b0;
        case (field_count)
          2'd1: begin
            raw_col     <= number;
            field_count <= 2'd2;
          end
          2'd2: field_count <= 2'd0;
          default: begin
            // zero, and the unused code three, start a new triple
            raw_row     <= number;
            field_count <= 2'd1;
          end
        endcase
      end
    end
  end

endmodule

/* hdl/gcs_tracker.sv */
// Four-mode gaze tracker: jump filter, closed-eye select and cursor stepping.
// Runs once per completed triple. Depends on gcs_pkg.
module gcs_tracker
  import gcs_pkg::*;
#(
  parameter int KEY_COUNT     = 50,
  parameter int REOPEN_MARGIN = 400
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  gcs_triple_t triple,
  input  gcs_cfg_t    cfg,
  output gcs_result_t result
);

  localparam logic [5:0]  KEY_LAST = 6'(KEY_COUNT);
  localparam logic [16:0] MARGIN   = 17'(REOPEN_MARGIN);

  track_state_t state, state_next;
  logic [15:0] origin_row, origin_row_next;
  logic [15:0] origin_col, origin_col_next;
  logic [15:0] last_row, last_row_next;
  logic [15:0] last_col, last_col_next;
  logic [15:0] shown_row, shown_row_next;
  logic [15:0] shown_col, shown_col_next;
  logic [7:0]  closed_count, closed_count_next;
  logic [5:0]  cursor, cursor_next;

  logic [15:0] jump_row, jump_col;
  logic        jump_ok;
  logic [15:0] flt_row, flt_col;
  logic        col_ahead;
  logic [15:0] off_row, off_col;
  logic [7:0]  count_inc;
  logic [5:0]  cursor_left, cursor_right;
  logic [16:0] bright_level;
  logic        select_pulse;
  logic [1:0]  mode_code;

  // Jump filter against the last accepted position
  always_comb begin
    jump_row = (triple.row >= last_row) ? triple.row - last_row : last_row - triple.row;
    jump_col = (triple.col >= last_col) ? triple.col - last_col : last_col - triple.col;
    jump_ok  = (jump_row < cfg.jump_limit) && (jump_col < cfg.jump_limit);
    flt_row  = jump_ok ? triple.row : last_row;
    flt_col  = jump_ok ? triple.col : last_col;
  end

  // Offsets of the filtered position from the origin
  always_comb begin
    col_ahead = flt_col > origin_col;
    off_col   = col_ahead ? flt_col - origin_col : origin_col - flt_col;
    off_row   = (flt_row >= origin_row) ? flt_row - origin_row : origin_row - flt_row;
  end

  // Wrapping cursor steps and helpers
  always_comb begin
    cursor_left  = (cursor <= 6'd1 || cursor > KEY_LAST) ? KEY_LAST : cursor - 6'd1;
    cursor_right = (cursor >= KEY_LAST || cursor < 6'd1) ? 6'd1 : cursor + 6'd1;
    count_inc    = (closed_count == 8'hFF) ? closed_count : closed_count + 8'd1;
    bright_level = {1'b0, cfg.good_intensity} + MARGIN;
  end

  // Mode transitions
  always_comb begin
    state_next        = state;
    origin_row_next   = origin_row;
    origin_col_next   = origin_col;
    last_row_next     = last_row;
    last_col_next     = last_col;
    shown_row_next    = shown_row;
    shown_col_next    = shown_col;
    closed_count_next = closed_count;
    cursor_next       = cursor;
    select_pulse      = 1'b0;
    unique case (state)
      ST_INIT: begin
        if (triple.intensity >= cfg.good_intensity) begin
          origin_row_next = triple.row;
          origin_col_next = triple.col;
          last_row_next   = triple.row;
          last_col_next   = triple.col;
          state_next      = ST_CENTRAL;
        end
      end
      ST_CENTRAL: begin
        if (triple.intensity < cfg.closed_intensity) begin
          if (count_inc >= cfg.closed_frames_needed) begin
            state_next        = ST_CLOSED;
            select_pulse      = 1'b1;
            closed_count_next = '0;
          end else begin
            closed_count_next = count_inc;
          end
        end else begin
          closed_count_next = '0;
          last_row_next     = flt_row;
          last_col_next     = flt_col;
          shown_row_next    = flt_row;
          shown_col_next    = flt_col;
          if (off_col > cfg.move_offset) begin
            cursor_next = col_ahead ? cursor_right : cursor_left;
            state_next  = ST_MOVE;
          end
        end
      end
      ST_CLOSED: begin
        if (triple.intensity > cfg.open_intensity) state_next = ST_INIT;
      end
      ST_MOVE: begin
        last_row_next  = flt_row;
        last_col_next  = flt_col;
        shown_row_next = flt_row;
        shown_col_next = flt_col;
        if ({1'b0, triple.intensity} >= bright_level ||
            (off_row < cfg.move_offset && off_col < cfg.move_offset)) begin
          state_next = ST_CENTRAL;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Encode the mode for the output
  always_comb begin
    unique case (state_next)
      ST_INIT:    mode_code = MODE_INIT;
      ST_CENTRAL: mode_code = MODE_CENTRAL;
      ST_CLOSED:  mode_code = MODE_CLOSED;
      ST_MOVE:    mode_code = MODE_MOVE;
      default:    mode_code = MODE_INIT;
    endcase
  end

  always_comb begin
    result.mode            = mode_code;
    result.key_index       = cursor_next;
    result.select_pulse    = select_pulse;
    result.row_shown       = shown_row_next;
    result.col_shown       = shown_col_next;
    result.intensity_shown = triple.intensity;
  end

  // Tracker state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      origin_row   <= '0;
      origin_col   <= '0;
      last_row     <= '0;
      last_col     <= '0;
      shown_row    <= '0;
      shown_col    <= '0;
      closed_count <= '0;
      cursor       <= 6'd1;
    end else if (advance && triple.valid) begin
      state        <= state_next;
      origin_row   <= origin_row_next;
      origin_col   <= origin_col_next;
      last_row     <= last_row_next;
      last_col     <= last_col_next;
      shown_row    <= shown_row_next;
      shown_col    <= shown_col_next;
      closed_count <= closed_count_next;
      cursor       <= cursor_next;
    end
  end

endmodule

/* hdl/gaze_cursor_select_fsm_top.sv */
// Top level of the gaze cursor select tracker: input register, config
// registers, result register. Depends on gcs_pkg, gcs_assemble, gcs_tracker.
//
// Usage:
//   Input channel (in_valid/in_stall/rx_byte) carries one received byte per
//   transaction, high byte of each 16-bit number first. Every six bytes make
//   a row, column, intensity triple; the sixth byte yields one result
//   transaction on the output channel (out_valid/out_stall and the fields).
//   Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
//   is always high, and indexes above five are ignored.
//   Path: a byte accepted into the input register is processed as it drains,
//   and a completed triple's result is loaded into the result register.
//   Throughput: one byte per cycle while the input register is not stalled;
//   a triple completes on every sixth byte.
//   Stall: a held result blocks only a byte that would complete a new triple;
//   other bytes keep flowing. in_stall rises when the input register is full
//   and cannot drain.
//   Reset (rst, synchronous): empties both registers, restores the register
//   defaults, and puts the tracker in initialize with the cursor at one.
module gaze_cursor_select_fsm_top
  import gcs_pkg::*;
#(
  parameter int KEY_COUNT     = 50,
  parameter int REOPEN_MARGIN = 400
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  mode,
  output logic [5:0]  key_index,
  output logic        select_pulse,
  output logic [15:0] row_shown,
  output logic [15:0] col_shown,
  output logic [15:0] intensity_shown,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_fire;
  logic        in_fire;
  gcs_cfg_t    cfg;
  gcs_triple_t triple;
  gcs_result_t result;
  gcs_result_t out_reg;

  // Drain the input register unless it completes a triple into a held result
  assign s1_fire  = s1_valid && (!triple.valid || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_byte <= rx_byte;
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.good_intensity       <= 16'd600;
      cfg.closed_intensity     <= 16'd200;
      cfg.open_intensity       <= 16'd400;
      cfg.closed_frames_needed <= 8'd5;
      cfg.move_offset          <= 16'd10;
      cfg.jump_limit           <= 16'd50;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GOOD_INTENSITY: begin
          if (cfg_data > GOOD_INTENSITY_FLOOR) cfg.good_intensity <= cfg_data;
        end
        REG_CLOSED_INTENSITY: cfg.closed_intensity     <= cfg_data;
        REG_OPEN_INTENSITY:   cfg.open_intensity       <= cfg_data;
        REG_CLOSED_FRAMES:    cfg.closed_frames_needed <= cfg_data[7:0];
        REG_MOVE_OFFSET:      cfg.move_offset          <= cfg_data;
        REG_JUMP_LIMIT:       cfg.jump_limit           <= cfg_data;
        default: ;
      endcase
    end
  end

  gcs_assemble u_assemble (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_fire),
    .byte_in (s1_byte),
    .triple  (triple)
  );

  gcs_tracker #(
    .KEY_COUNT     (KEY_COUNT),
    .REOPEN_MARGIN (REOPEN_MARGIN)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_fire),
    .triple  (triple),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && triple.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && triple.valid) out_reg <= result;
  end

  assign mode            = out_reg.mode;
  assign key_index       = out_reg.key_index;
  assign select_pulse    = out_reg.select_pulse;
  assign row_shown       = out_reg.row_shown;
  assign col_shown       = out_reg.col_shown;
  assign intensity_shown = out_reg.intensity_shown;

endmodule

/* tb/gcs_cursor_checker.sv */
// Checker for the gaze cursor select tracker: watches the byte, result and
// register channels, predicts each result and compares it field by field.
// Depends on gcs_pkg.
module gcs_cursor_checker
  import gcs_pkg::*;
#(
  parameter int KEY_COUNT     = 50,
  parameter int REOPEN_MARGIN = 400
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  mode,
  input  logic [5:0]  key_index,
  input  logic        select_pulse,
  input  logic [15:0] row_shown,
  input  logic [15:0] col_shown,
  input  logic [15:0] intensity_shown,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          n_pending,
  output int          n_errors,
  output int          n_checked
);

  // Register copy
  logic [15:0] cfg_good, cfg_closed, cfg_open, cfg_move, cfg_jump;
  logic [7:0]  cfg_frames;

  // Byte assembler and tracker state
  logic        low_next;
  logic [15:0] part_num;
  logic [1:0]  fcount;
  logic [15:0] raw_r, raw_c, org_r, org_c, last_r, last_c, shown_r, shown_c;
  logic [1:0]  tmode;
  logic [7:0]  closed_cnt;
  logic [5:0]  cur;

  // Results predicted but not yet taken from the block
  gcs_result_t reports_due[$];

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (n_errors < 20)
      $display("mismatch at result %0d, %s: got %h, expected %h", n_checked, what, got, want);
    n_errors++;
  endtask

  task automatic clear_tracker();
    cfg_good = 16'd600; cfg_closed = 16'd200; cfg_open = 16'd400;
    cfg_frames = 8'd5; cfg_move = 16'd10; cfg_jump = 16'd50;
    low_next = 1'b0; part_num = '0; fcount = '0;
    raw_r = '0; raw_c = '0; org_r = '0; org_c = '0; last_r = '0; last_c = '0;
    shown_r = '0; shown_c = '0; tmode = MODE_INIT; closed_cnt = '0; cur = 6'd1;
    reports_due.delete();
  endtask

  task automatic apply_register(logic [2:0] idx, logic [15:0] data);
    case (idx)
      REG_GOOD_INTENSITY:   if (data > GOOD_INTENSITY_FLOOR) cfg_good = data;
      REG_CLOSED_INTENSITY: cfg_closed = data;
      REG_OPEN_INTENSITY:   cfg_open = data;
      REG_CLOSED_FRAMES:    cfg_frames = data[7:0];
      REG_MOVE_OFFSET:      cfg_move = data;
      REG_JUMP_LIMIT:       cfg_jump = data;
      default: ;
    endcase
  endtask

  // Jump filter: keep the last position if either axis jumped too far
  task automatic filter_sample();
    int dr, dc;
    dr = int'(raw_r) - int'(last_r);
    dc = int'(raw_c) - int'(last_c);
    if (!(mag(dr) >= int'(cfg_jump) || mag(dc) >= int'(cfg_jump))) begin
      last_r = raw_r;
      last_c = raw_c;
    end
    shown_r = last_r;
    shown_c = last_c;
  endtask

  task automatic step_cursor(bit right);
    if (right) begin
      if (cur >= KEY_COUNT || cur < 1) cur = 6'd1;
      else cur = cur + 6'd1;
    end else begin
      if (cur <= 1 || cur > KEY_COUNT) cur = 6'(KEY_COUNT);
      else cur = cur - 6'd1;
    end
  endtask

  // One tracker step per completed triple
  task automatic run_gaze_tracker(input logic [15:0] inten, output logic sel);
    int dr, dc;
    sel = 1'b0;
    case (tmode)
      MODE_INIT: begin
        if (inten >= cfg_good) begin
          org_r = raw_r; org_c = raw_c;
          last_r = raw_r; last_c = raw_c;
          tmode = MODE_CENTRAL;
        end
      end
      MODE_CENTRAL: begin
        if (inten < cfg_closed) begin
          if (closed_cnt != 8'hFF) closed_cnt = closed_cnt + 8'd1;
          if (closed_cnt >= cfg_frames) begin
            tmode = MODE_CLOSED;
            sel = 1'b1;
            closed_cnt = '0;
          end
        end else begin
          closed_cnt = '0;
          filter_sample();
          dc = int'(last_c) - int'(org_c);
          if (dc > int'(cfg_move)) begin
            step_cursor(1'b1);
            tmode = MODE_MOVE;
          end else if (dc < -int'(cfg_move)) begin
            step_cursor(1'b0);
            tmode = MODE_MOVE;
          end
        end
      end
      MODE_CLOSED: begin
        if (inten > cfg_open) tmode = MODE_INIT;
      end
      default: begin
        filter_sample();
        dr = int'(last_r) - int'(org_r);
        dc = int'(last_c) - int'(org_c);
        // sum is taken wide, so a bright limit above 16 bits never matches
        if (int'(inten) >= int'(cfg_good) + REOPEN_MARGIN ||
            (mag(dr) < int'(cfg_move) && mag(dc) < int'(cfg_move)))
          tmode = MODE_CENTRAL;
      end
    endcase
  endtask

  // Byte pairing, triple grouping and result prediction
  task automatic absorb_byte(logic [7:0] b);
    logic        sel;
    gcs_result_t r;
    if (!low_next) begin
      part_num = {b, 8'h00};
      low_next = 1'b1;
    end else begin
      part_num = part_num + 16'(b);
      low_next = 1'b0;
      if (fcount == 2'd1) begin
        raw_c = part_num;
        fcount = 2'd2;
      end else if (fcount != 2'd2) begin
        raw_r = part_num;
        fcount = 2'd1;
      end else begin
        fcount = 2'd0;
        run_gaze_tracker(part_num, sel);
        r.mode = tmode;
        r.key_index = cur;
        r.select_pulse = sel;
        r.row_shown = shown_r;
        r.col_shown = shown_c;
        r.intensity_shown = part_num;
        reports_due.push_back(r);
      end
    end
  endtask

  task automatic check_report();
    gcs_result_t want;
    if (reports_due.size() == 0) begin
      report_mismatch("result with none due, intensity", intensity_shown, 16'h0);
      return;
    end
    want = reports_due.pop_front();
    n_checked++;
    if (mode !== want.mode) report_mismatch("mode", 16'(mode), 16'(want.mode));
    if (key_index !== want.key_index)
      report_mismatch("key_index", 16'(key_index), 16'(want.key_index));
    if (select_pulse !== want.select_pulse)
      report_mismatch("select_pulse", 16'(select_pulse), 16'(want.select_pulse));
    if (row_shown !== want.row_shown) report_mismatch("row_shown", row_shown, want.row_shown);
    if (col_shown !== want.col_shown) report_mismatch("col_shown", col_shown, want.col_shown);
    if (intensity_shown !== want.intensity_shown)
      report_mismatch("intensity_shown", intensity_shown, want.intensity_shown);
  endtask

  // Older results are compared before this edge's byte is absorbed
  always @(posedge clk) begin
    if (rst) begin
      clear_tracker();
    end else begin
      if (out_valid && !out_stall) check_report();
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) absorb_byte(rx_byte);
    end
    n_pending <= reports_due.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for gaze_cursor_select_fsm_top: drives byte and register
// transactions, random idles and result stalls, and gives the verdict.
// Depends on gcs_pkg, gcs_cursor_checker and the block's RTL.
module tb_top
  import gcs_pkg::*;
();

  localparam int KEY_COUNT     = 50;
  localparam int REOPEN_MARGIN = 400;
  localparam int RUN_LIMIT     = 100000;
  localparam int PHASES        = 12;
  localparam int PHASE_BYTES   = 146;

  // Indexes past the last register; writes there are ignored
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = REG_GOOD_INTENSITY;
  logic [15:0] cfg_data  = 16'h0000;
  logic        in_stall, out_valid, cfg_ready, select_pulse;
  logic [1:0]  mode;
  logic [5:0]  key_index;
  logic [15:0] row_shown, col_shown, intensity_shown;

  int n_pending, n_errors, n_checked;
  int cycles     = 0;
  int bytes_sent = 0;
  int byte_phase = 0;
  int reg_writes = 0;
  bit quiet      = 1'b0;

  // Register values as seen by the stimulus shaping
  int sh_good = 600, sh_closed = 200, sh_open = 400;
  int sh_move = 10;

  gaze_cursor_select_fsm_top #(
    .KEY_COUNT(KEY_COUNT),
    .REOPEN_MARGIN(REOPEN_MARGIN)
  ) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .mode(mode), .key_index(key_index), .select_pulse(select_pulse),
    .row_shown(row_shown), .col_shown(col_shown), .intensity_shown(intensity_shown),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gcs_cursor_checker #(
    .KEY_COUNT(KEY_COUNT),
    .REOPEN_MARGIN(REOPEN_MARGIN)
  ) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .mode(mode), .key_index(key_index), .select_pulse(select_pulse),
    .row_shown(row_shown), .col_shown(col_shown), .intensity_shown(intensity_shown),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .n_pending(n_pending), .n_errors(n_errors), .n_checked(n_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, n_pending);
      $display("** gaze_cursor_select_fsm_top: FAILED **");
      $finish;
    end
  end

  function automatic int clamp16(int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  // Mostly near the center, now and then anywhere
  function automatic int pick_position(int center, int spread);
    if ($urandom_range(99) < 5) return int'($urandom_range(65535));
    return clamp16(center + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // Intensity classes around the current thresholds
  function automatic int pick_intensity();
    int sel, lo, hi;
    sel = $urandom_range(99);
    if (sel < 25) return (sh_closed == 0) ? 0 : int'($urandom_range(sh_closed - 1, 0));
    if (sel < 40) begin
      lo = (sh_closed < sh_open) ? sh_closed : sh_open;
      hi = (sh_closed < sh_open) ? sh_open : sh_closed;
      return int'($urandom_range(hi, lo));
    end
    if (sel < 55) return clamp16(sh_open + 1 + int'($urandom_range(300)));
    if (sel < 75) return clamp16(sh_good + int'($urandom_range(300)));
    if (sel < 85) return clamp16(sh_good + REOPEN_MARGIN + int'($urandom_range(50)));
    if (sel < 92) begin
      case ($urandom_range(3))
        0: return sh_closed;
        1: return sh_open;
        2: return sh_good;
        default: return clamp16(sh_good + REOPEN_MARGIN - 1);
      endcase
    end
    return int'($urandom_range(65535));
  endfunction

  // One byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    byte_phase = (byte_phase + 1) % 6;
  endtask

  // Finishes any broken triple with random bytes first
  task automatic send_triple(input int row, input int col, input int inten);
    logic [15:0] n [3];
    n[0] = 16'(row);
    n[1] = 16'(col);
    n[2] = 16'(inten);
    while (byte_phase != 0) send_byte(8'($urandom));
    foreach (n[i]) begin
      send_byte(n[i][15:8]);
      send_byte(n[i][7:0]);
    end
  endtask

  // Valid stays high across back-to-back writes; the caller lowers it
  task automatic write_reg(input logic [2:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic configure(int g, int cl, int op, int fr, int mv, int jp, bit spare);
    write_reg(REG_GOOD_INTENSITY, g);
    write_reg(REG_CLOSED_INTENSITY, cl);
    write_reg(REG_OPEN_INTENSITY, op);
    write_reg(REG_CLOSED_FRAMES, fr);
    write_reg(REG_MOVE_OFFSET, mv);
    write_reg(REG_JUMP_LIMIT, jp);
    if (spare) write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, int'($urandom));
    cfg_valid <= 1'b0;
    if (g > int'(GOOD_INTENSITY_FLOOR)) sh_good = g;
    sh_closed = cl; sh_open = op; sh_move = mv;
  endtask

  // Hold the input side until every result is in and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int g, cl, op, fr, mv, jp, cr, cc, rs, cs, start;
    bit spare;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme coordinates, init rejected then accepted, a right move
    send_triple(16'h0000, 16'hFFFF, 16'h0000);
    send_triple(16'hFFFF, 16'h00FF, 16'hFFFF);
    send_triple(16'hFFFF, 16'h0100, 700);
    send_triple(16'hFFF0, 16'h0120, 700);

    for (int k = 0; k < PHASES; k++) begin
      drain();
      g  = $urandom_range(3000, 101);
      cl = $urandom_range(800);
      op = cl + int'($urandom_range(600));
      fr = $urandom_range(8, 1);
      mv = $urandom_range(40, 1);
      jp = $urandom_range(mv * 10 + 20, mv * 2 + 1);
      spare = ($urandom_range(3) == 0);
      cr = $urandom_range(64000, 1000);
      cc = $urandom_range(64000, 1000);
      case (k)
        // lowest settings: every frame open, jump window that passes no movement
        0: begin
          g = 101; cl = 0; op = 0; fr = 0; mv = 0; jp = 1; spare = 1'b1;
          cr = 0; cc = 0;
        end
        // floor write ignored, first closed frame selects, every sample rejected
        1: begin
          g = int'(GOOD_INTENSITY_FLOOR); cl = 300; op = 350; fr = 0; mv = 5; jp = 0;
          spare = 1'b1;
        end
        // highest settings: bright limit past 16 bits
        2: begin
          g = 65535; cl = 65535; op = 65535; fr = 255; mv = 65535; jp = 65535;
          cr = 65535; cc = 65535;
        end
        default: ;
      endcase
      configure(g, cl, op, fr, mv, jp, spare);
      rs = (sh_move + 3 > 2000) ? 2000 : sh_move + 3;
      cs = (sh_move * 2 + 4 > 2000) ? 2000 : sh_move * 2 + 4;
      quiet <= (k == 3);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
        end else begin
          send_triple(pick_position(cr, rs), pick_position(cc, cs), pick_intensity());
        end
      end
    end

    drain();
    $display("covered %0d bytes and %0d tracker results over %0d register phases",
             bytes_sent, n_checked, PHASES);
    $display("register writes: %0d, including ignored ones and both threshold extremes",
             reg_writes);
    if (n_errors == 0) begin
      $display("** gaze_cursor_select_fsm_top: PASSED **");
    end else begin
      $display("** gaze_cursor_select_fsm_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/gcs_pkg.sv
hdl/gcs_assemble.sv
hdl/gcs_tracker.sv
hdl/gaze_cursor_select_fsm_top.sv
tb/gcs_cursor_checker.sv
tb/tb_top.sv
